[rtl/mi3_pkg.sv]
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int ADJ_W  = 2 * ELEM_W + 1;
  localparam int DET_W  = 3 * ELEM_W + 3;
  localparam int NUM_ELEMS = 9;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;

  // cofactor k = e[I]*e[J] - e[K]*e[L], indexed into row-major elements
  localparam int CF_I [NUM_ELEMS] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int CF_J [NUM_ELEMS] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int CF_K [NUM_ELEMS] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int CF_L [NUM_ELEMS] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  localparam int ADJ_LAT = 6;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_item_t;

  typedef struct packed {
    elem_t out_r0c0;
    elem_t out_r0c1;
    elem_t out_r0c2;
    elem_t out_r1c0;
    elem_t out_r1c1;
    elem_t out_r1c2;
    elem_t out_r2c0;
    elem_t out_r2c1;
    elem_t out_r2c2;
    logic  singular;
    logic  saturated;
  } out_item_t;

endpackage

[rtl/mi3_adj.sv]
module mi3_adj (
  input  logic                          clk,
  input  logic                          en,
  input  mi3_pkg::elem_t                e     [mi3_pkg::NUM_ELEMS],
  output mi3_pkg::adj_t                 adj   [mi3_pkg::NUM_ELEMS],
  output logic [mi3_pkg::DET_W-1:0]     dmag,
  output logic                          dneg,
  output logic                          dzero
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int AW = mi3_pkg::ADJ_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int PW = 2 * EW + 1;

  logic signed [2*EW-1:0] pa_r [mi3_pkg::NUM_ELEMS];
  logic signed [2*EW-1:0] pb_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t adj2_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t adj3_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t adj4_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t adj5_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t adj6_r [mi3_pkg::NUM_ELEMS];
  mi3_pkg::elem_t top1_r [3];
  mi3_pkg::elem_t top2_r [3];
  logic signed [PW-1:0] plo_r [3];
  logic signed [PW-1:0] phi_r [3];
  logic signed [DW-1:0] term_r [3];
  logic signed [DW-1:0] det_r;
  logic signed [DW-1:0] det_neg;
  logic [DW-1:0] dmag_r;
  logic dneg_r;
  logic dzero_r;

  for (genvar g = 0; g < mi3_pkg::NUM_ELEMS; g++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[g]   <= e[mi3_pkg::CF_I[g]] * e[mi3_pkg::CF_J[g]];
        pb_r[g]   <= e[mi3_pkg::CF_K[g]] * e[mi3_pkg::CF_L[g]];
        adj2_r[g] <= AW'(pa_r[g]) - AW'(pb_r[g]);
        adj3_r[g] <= adj2_r[g];
        adj4_r[g] <= adj3_r[g];
        adj5_r[g] <= adj4_r[g];
        adj6_r[g] <= adj5_r[g];
      end
    end
    assign adj[g] = adj6_r[g];
  end

  // first-row expansion; 65-bit cofactor split into two partial products
  for (genvar t = 0; t < 3; t++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        top1_r[t] <= e[t];
        top2_r[t] <= top1_r[t];
        plo_r[t]  <= top2_r[t] * signed'({1'b0, adj2_r[3*t][EW-1:0]});
        phi_r[t]  <= top2_r[t] * signed'(adj2_r[3*t][AW-1:EW]);
        term_r[t] <= (DW'(phi_r[t]) <<< EW) + DW'(plo_r[t]);
      end
    end
  end

  assign det_neg = -det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r   <= term_r[0] + term_r[1] + term_r[2];
      dneg_r  <= det_r[DW-1];
      dmag_r  <= det_r[DW-1] ? det_neg : det_r;
      dzero_r <= (det_r == '0);
    end
  end

  assign dmag  = dmag_r;
  assign dneg  = dneg_r;
  assign dzero = dzero_r;

endmodule

[rtl/mi3_lane.sv]
module mi3_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  mi3_pkg::adj_t             adj,
  input  logic [mi3_pkg::DET_W-1:0] dmag,
  input  logic                      dneg,
  output mi3_pkg::elem_t            q,
  output logic                      sat
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int AW = mi3_pkg::ADJ_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int NW = AW + 2 * FRAC_BITS;
  localparam int SW = DW + EW + 1;
  localparam int RW = (NW > SW) ? NW : SW;
  localparam int QW = EW + 1;

  logic [RW-1:0] rem_r  [EW+1];
  logic [DW-1:0] dmag_r [EW+2];
  logic [QW-1:0] q_r    [EW+2];
  logic          neg_r  [EW+2];
  logic          big_r  [EW+2];
  logic [AW-1:0] mag;
  logic [QW-1:0] lim;
  logic [QW-1:0] qv;
  logic [QW-1:0] qs;
  logic          ov;
  mi3_pkg::elem_t q_o_r;
  logic           sat_o_r;

  assign mag = adj[AW-1] ? AW'(-adj) : AW'(adj);

  // entry stage: magnitude, scale, sign, quotient-too-wide check
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RW'(mag) << (2 * FRAC_BITS);
      dmag_r[0] <= dmag;
      neg_r[0]  <= adj[AW-1] ^ dneg;
      big_r[0]  <= (RW'(mag) << (2 * FRAC_BITS)) >= (RW'(dmag) << QW);
      q_r[0]    <= '0;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = EW - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(dmag_r[k]) << B;
    assign ge = rem_r[k] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        dmag_r[k+1] <= dmag_r[k];
        neg_r[k+1]  <= neg_r[k];
        big_r[k+1]  <= big_r[k];
        q_r[k+1]    <= {q_r[k][QW-2:0], ge};
      end
    end
    if (k < EW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? rem_r[k] - sh : rem_r[k];
        end
      end
    end
  end

  always_comb begin
    lim = neg_r[QW] ? (QW'(1) << (EW - 1)) : ((QW'(1) << (EW - 1)) - QW'(1));
    ov  = big_r[QW] || (q_r[QW] > lim);
    qv  = ov ? lim : q_r[QW];
    qs  = neg_r[QW] ? -qv : qv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o_r   <= qs[EW-1:0];
      sat_o_r <= ov;
    end
  end

  assign q   = q_o_r;
  assign sat = sat_o_r;

endmodule

[rtl/matrix_inverse_3x3.sv]
// 3x3 matrix inverse, signed Q16.16 in and out (fraction bits set by
// FRAC_BITS). Fully pipelined: one matrix per clock is accepted unless an
// output transfer is stalled. Six stages form the adjugate and determinant,
// then nine parallel lanes each run a restoring divider with one quotient
// bit per stage, and one output register merges the lanes. Quotients round
// toward zero and clamp to the element range (saturated set); a zero
// determinant yields all-zero entries with singular set. The whole pipeline
// holds while an output transfer is stalled.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::out_item_t out_data
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int LANE_LAT = EW + 3;
  localparam int LAT = mi3_pkg::ADJ_LAT + LANE_LAT;

  logic en;
  logic vld_r [LAT];
  logic zero_r [LANE_LAT];
  logic out_valid_r;
  mi3_pkg::out_item_t out_r;
  mi3_pkg::out_item_t out_nxt;

  mi3_pkg::elem_t e   [mi3_pkg::NUM_ELEMS];
  mi3_pkg::adj_t  adj [mi3_pkg::NUM_ELEMS];
  mi3_pkg::elem_t q   [mi3_pkg::NUM_ELEMS];
  logic           sat [mi3_pkg::NUM_ELEMS];
  logic [mi3_pkg::DET_W-1:0] dmag;
  logic dneg;
  logic dzero;
  logic any_sat;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign e[0] = in_data.in_r0c0;
  assign e[1] = in_data.in_r0c1;
  assign e[2] = in_data.in_r0c2;
  assign e[3] = in_data.in_r1c0;
  assign e[4] = in_data.in_r1c1;
  assign e[5] = in_data.in_r1c2;
  assign e[6] = in_data.in_r2c0;
  assign e[7] = in_data.in_r2c1;
  assign e[8] = in_data.in_r2c2;

  mi3_adj u_adj (
    .clk   (clk),
    .en    (en),
    .e     (e),
    .adj   (adj),
    .dmag  (dmag),
    .dneg  (dneg),
    .dzero (dzero)
  );

  for (genvar g = 0; g < mi3_pkg::NUM_ELEMS; g++) begin : g_lane
    mi3_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .adj  (adj[g]),
      .dmag (dmag),
      .dneg (dneg),
      .q    (q[g]),
      .sat  (sat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= dzero;
      for (int i = 1; i < LANE_LAT; i++) begin
        zero_r[i] <= zero_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < mi3_pkg::NUM_ELEMS; i++) begin
      any_sat = any_sat | sat[i];
    end
    if (zero_r[LANE_LAT-1]) begin
      out_nxt = '0;
      out_nxt.singular = 1'b1;
    end else begin
      out_nxt.out_r0c0  = q[0];
      out_nxt.out_r0c1  = q[1];
      out_nxt.out_r0c2  = q[2];
      out_nxt.out_r1c0  = q[3];
      out_nxt.out_r1c1  = q[4];
      out_nxt.out_r1c2  = q[5];
      out_nxt.out_r2c0  = q[6];
      out_nxt.out_r2c1  = q[7];
      out_nxt.out_r2c2  = q[8];
      out_nxt.singular  = 1'b0;
      out_nxt.saturated = any_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 600;

  class inverse_scoreboard;
    mi3_pkg::out_item_t expected_q[$];
    int mismatches = 0;
    int unexpected = 0;

    function automatic mi3_pkg::out_item_t invert(mi3_pkg::in_item_t m);
      logic signed [127:0] e[9];
      logic signed [127:0] adj[9];
      logic signed [127:0] det;
      logic [127:0] num, den, quo, lim;
      logic [31:0] v[9];
      logic neg, sat;
      mi3_pkg::out_item_t r;
      e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
      e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
      e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
      adj[0] = e[4] * e[8] - e[7] * e[5];
      adj[1] = e[2] * e[7] - e[1] * e[8];
      adj[2] = e[1] * e[5] - e[2] * e[4];
      adj[3] = e[5] * e[6] - e[3] * e[8];
      adj[4] = e[0] * e[8] - e[2] * e[6];
      adj[5] = e[3] * e[2] - e[0] * e[5];
      adj[6] = e[3] * e[7] - e[6] * e[4];
      adj[7] = e[6] * e[1] - e[0] * e[7];
      adj[8] = e[0] * e[4] - e[3] * e[1];
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      sat = 1'b0;
      if (det == 0) begin
        r = '0;
        r.singular = 1'b1;
        return r;
      end
      den = (det < 0) ? -det : det;
      for (int k = 0; k < 9; k++) begin
        neg = (adj[k] < 0) != (det < 0);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        num = ((adj[k] < 0) ? -adj[k] : adj[k]) << 32;
        quo = num / den;
        if (quo > lim) begin
          quo = lim;
          sat = 1'b1;
        end
        v[k] = neg ? 32'(-quo) : 32'(quo);
      end
      r.out_r0c0 = v[0]; r.out_r0c1 = v[1]; r.out_r0c2 = v[2];
      r.out_r1c0 = v[3]; r.out_r1c1 = v[4]; r.out_r1c2 = v[5];
      r.out_r2c0 = v[6]; r.out_r2c1 = v[7]; r.out_r2c2 = v[8];
      r.singular = 1'b0;
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(mi3_pkg::in_item_t m);
      expected_q.push_back(invert(m));
    endfunction

    function void check_result(mi3_pkg::out_item_t got);
      mi3_pkg::out_item_t exp_r;
      logic [31:0] ev[9], gv[9];
      bit bad;
      if (expected_q.size() == 0) begin
        unexpected++;
        $display("unexpected result transfer: %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      ev = '{exp_r.out_r0c0, exp_r.out_r0c1, exp_r.out_r0c2, exp_r.out_r1c0,
             exp_r.out_r1c1, exp_r.out_r1c2, exp_r.out_r2c0, exp_r.out_r2c1,
             exp_r.out_r2c2};
      gv = '{got.out_r0c0, got.out_r0c1, got.out_r0c2, got.out_r1c0,
             got.out_r1c1, got.out_r1c2, got.out_r2c0, got.out_r2c1,
             got.out_r2c2};
      bad = 0;
      for (int k = 0; k < 9; k++)
        if (ev[k] !== gv[k]) begin
          bad = 1;
          if (mismatches < 10)
            $display("entry r%0dc%0d: expected %h got %h", k / 3, k % 3, ev[k], gv[k]);
        end
      if (exp_r.singular !== got.singular) begin
        bad = 1;
        if (mismatches < 10)
          $display("singular: expected %b got %b", exp_r.singular, got.singular);
      end
      if (exp_r.saturated !== got.saturated) begin
        bad = 1;
        if (mismatches < 10)
          $display("saturated: expected %b got %b", exp_r.saturated, got.saturated);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  mi3_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  mi3_pkg::out_item_t out_data;

  inverse_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit hold_done = 0;

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic mi3_pkg::in_item_t pack_matrix(mi3_pkg::elem_t a[9]);
    mi3_pkg::in_item_t m;
    m.in_r0c0 = a[0]; m.in_r0c1 = a[1]; m.in_r0c2 = a[2];
    m.in_r1c0 = a[3]; m.in_r1c1 = a[4]; m.in_r1c2 = a[5];
    m.in_r2c0 = a[6]; m.in_r2c1 = a[7]; m.in_r2c2 = a[8];
    return m;
  endfunction

  function automatic mi3_pkg::elem_t rand_elem(int mode);
    mi3_pkg::elem_t pick[6];
    pick = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 32'sh1, -32'sh1, 32'sh1_0000};
    case (mode)
      0: return mi3_pkg::elem_t'($urandom);
      1: return mi3_pkg::elem_t'(int'($urandom_range(0, 524288)) - 262144);
      2: return mi3_pkg::elem_t'(int'($urandom_range(0, 16)) - 8);
      default: return pick[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic mi3_pkg::in_item_t rand_matrix();
    mi3_pkg::elem_t a[9];
    int mode, k;
    mode = $urandom_range(0, 3);
    foreach (a[i]) a[i] = rand_elem($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
    // some matrices made singular on purpose
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) a[6 + i] = a[i];
      1: begin
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) a[3 * i + k] = '0;
      end
      default: ;
    endcase
    return pack_matrix(a);
  endfunction

  task automatic send_matrix(mi3_pkg::in_item_t m);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(m);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_diag(mi3_pkg::elem_t d0, mi3_pkg::elem_t d1, mi3_pkg::elem_t d2);
    mi3_pkg::elem_t a[9];
    a = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
    send_matrix(pack_matrix(a));
  endtask

  task automatic send_fill(mi3_pkg::elem_t x);
    mi3_pkg::elem_t a[9];
    foreach (a[i]) a[i] = x;
    send_matrix(pack_matrix(a));
  endtask

  // receiver: random stalls, one long hold to back up the pipeline
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 100) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end
      out_stall <= (!quiet && $urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    mi3_pkg::elem_t a[9];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);    // identity
    send_fill(32'sh0);                                   // zero matrix
    send_fill(32'sh1_0000);                              // rank one
    send_fill(32'sh7fff_ffff);
    send_fill(32'sh8000_0000);
    send_diag(32'sh1, 32'sh1, 32'sh1);                   // positive clamp
    send_diag(-32'sh1, 32'sh1, 32'sh1);                  // negative clamp
    send_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_diag(32'sh8000_0000, 32'sh7fff_ffff, -32'sh1);
    send_diag(32'sh2_0000, -32'sh4_0000, 32'sh0_8000);
    send_diag(32'sh10000, 32'sh10000, 32'sh0);           // singular diagonal
    a = '{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 0, 32'sh1_0000, 32'sh4_0000,
          32'sh5_0000, 32'sh6_0000, 0};
    send_matrix(pack_matrix(a));
    a = '{0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0};  // permutation
    send_matrix(pack_matrix(a));
    a = '{32'sh3, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh3, 32'sh0, -32'sh3, 32'sh0};
    send_matrix(pack_matrix(a));
    a = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh8000_0000, 32'sh1, -32'sh1, 32'sh5555_5555};
    send_matrix(pack_matrix(a));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 250 && n < 370);
      send_matrix(rand_matrix());
    end
    quiet = 0;
    in_valid <= 1'b0;

    wait (sb.expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[matrix_inverse_3x3.f]
rtl/mi3_pkg.sv
rtl/mi3_adj.sv
rtl/mi3_lane.sv
rtl/matrix_inverse_3x3.sv
tb/tb.sv
